/* src/dirty_slot_patch_builder_assert.svh */
// Assertion helpers shared by the checker.
`ifndef DIRTY_SLOT_PATCH_BUILDER_ASSERT_SVH
`define DIRTY_SLOT_PATCH_BUILDER_ASSERT_SVH

// Plain property, clocked and disabled in reset.
`define DSPB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same-cycle implication.
`define DSPB_IMPLY(lbl, clk, rst_n, cond, rhs, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (rhs)) else $error(msg);

`endif

/* src/dspb_pkg.sv */
package dspb_pkg;

    localparam int SLOTS        = 64;
    localparam int SLOT_WORDS   = 8;
    localparam int HEADER_WORDS = 3;
    localparam int MAX_RUNS     = 32;
    localparam int RUN_CAP      = 64;
    localparam int CAP_RESET    = 16;
    localparam int QUEUE_DEPTH  = 4;

    localparam int SLOT_W = 6;
    localparam int CNT_W  = 7;
    localparam int RUN_W  = 6;
    localparam int CFG_W  = 7;
    localparam int DST_W  = 9;
    localparam int SRC_W  = 10;
    localparam int LEN_W  = 10;
    localparam int OP_W   = 2;

    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = QPTR_W + 1;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_PATCH = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_MARK  = 2'd2,
        OP_FLUSH = 2'd3
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [SLOT_W-1:0] slot;
    } t_cmd;

endpackage

/* src/dirty_slot_patch_builder.sv */
// An appending allocation's reply is registered as its command leaves the queue; a reusing
// allocation first reads the free list into ST_POP, then registers the reply there.
// Back end: free, mark and an appending allocate are handled in ST_IDLE, a reusing allocate
// also passes ST_POP; a flush scans the live slots at most twice, one slot a cycle while the
// output is not stalled (count runs, then emit), and only once when nothing is dirty.
// Reset (i_rst_n low, synchronous): live count, free list depth and dirty bits clear, the
// command queue empties, max run length returns to 16; free list contents are kept.
module dirty_slot_patch_builder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [dspb_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [dspb_pkg::OP_W-1:0]     i_operation,
    input  logic [dspb_pkg::SLOT_W-1:0]   i_slot_index,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_result_kind,
    output logic [dspb_pkg::SLOT_W-1:0]   o_granted_slot,
    output logic                          o_table_full,
    output logic [dspb_pkg::DST_W-1:0]    o_dest_word,
    output logic [dspb_pkg::SRC_W-1:0]    o_source_word,
    output logic [dspb_pkg::LEN_W-1:0]    o_length_words,
    output logic                          o_last_patch
);
    import dspb_pkg::*;

    logic cmd_valid;
    t_cmd cmd;
    logic cmd_pop;

    assign o_cfg_ready = 1'b1;

    dspb_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_operation  (i_operation),
        .i_slot_index (i_slot_index),
        .o_cmd_valid  (cmd_valid),
        .o_cmd        (cmd),
        .i_cmd_pop    (cmd_pop)
    );

    dspb_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .i_cmd_valid    (cmd_valid),
        .i_cmd          (cmd),
        .o_cmd_pop      (cmd_pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_result_kind  (o_result_kind),
        .o_granted_slot (o_granted_slot),
        .o_table_full   (o_table_full),
        .o_dest_word    (o_dest_word),
        .o_source_word  (o_source_word),
        .o_length_words (o_length_words),
        .o_last_patch   (o_last_patch)
    );

endmodule

/* src/dspb_front.sv */
module dspb_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [dspb_pkg::OP_W-1:0]          i_operation,
    input  logic [dspb_pkg::SLOT_W-1:0]        i_slot_index,
    output logic                               o_cmd_valid,
    output dspb_pkg::t_cmd                     o_cmd,
    input  logic                               i_cmd_pop
);
    import dspb_pkg::*;

    t_cmd              r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_head;
    logic [QPTR_W-1:0] r_tail;
    logic [QCNT_W-1:0] r_count;
    logic [QPTR_W-1:0] n_head;
    logic [QPTR_W-1:0] n_tail;
    logic [QCNT_W-1:0] n_count;
    logic              push;
    logic              pop;
    t_cmd              cls_cmd;

    always_comb begin
        case (i_operation)
            OP_ALLOC: cls_cmd.op = OP_ALLOC;
            OP_FREE:  cls_cmd.op = OP_FREE;
            OP_MARK:  cls_cmd.op = OP_MARK;
            default:  cls_cmd.op = OP_FLUSH;
        endcase
        cls_cmd.slot = i_slot_index;
    end

    assign o_in_stall  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign push        = i_in_valid && !o_in_stall;
    assign pop         = i_cmd_pop && (r_count != '0);
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_q[r_head];

    always_comb begin
        n_head  = pop  ? r_head + QPTR_W'(1) : r_head;
        n_tail  = push ? r_tail + QPTR_W'(1) : r_tail;
        n_count = r_count + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
        if (push) begin
            r_q[r_tail] <= cls_cmd;
        end
    end

endmodule

/* src/dspb_back.sv */
module dspb_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic [dspb_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                          i_cmd_valid,
    input  dspb_pkg::t_cmd                i_cmd,
    output logic                          o_cmd_pop,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_result_kind,
    output logic [dspb_pkg::SLOT_W-1:0]   o_granted_slot,
    output logic                          o_table_full,
    output logic [dspb_pkg::DST_W-1:0]    o_dest_word,
    output logic [dspb_pkg::SRC_W-1:0]    o_source_word,
    output logic [dspb_pkg::LEN_W-1:0]    o_length_words,
    output logic                          o_last_patch
);
    import dspb_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP,
        ST_SCAN
    } t_state;

    t_state             r_state,  n_state;
    logic [CFG_W-1:0]   r_cap,    n_cap;
    logic [CNT_W-1:0]   r_live,   n_live;
    logic [CNT_W-1:0]   r_depth,  n_depth;
    logic [SLOTS-1:0]   r_dirty,  n_dirty;
    logic [SLOTS-1:0]   r_onstk,  n_onstk;
    logic [CNT_W-1:0]   r_idx,    n_idx;
    logic               r_adj,    n_adj;
    logic [CNT_W-1:0]   r_len,    n_len;
    logic [SLOT_W-1:0]  r_rs,     n_rs;
    logic [RUN_W-1:0]   r_k,      n_k;
    logic [RUN_W-1:0]   r_total,  n_total;
    logic [CNT_W-1:0]   r_data,   n_data;
    logic               r_pass,   n_pass;
    logic               r_out_valid, n_out_valid;

    logic [SLOT_W-1:0]  r_stack [SLOTS];
    logic [SLOT_W-1:0]  r_pop_slot;
    logic               stk_we;
    logic               stk_re;
    logic [SLOT_W-1:0]  stk_waddr;
    logic [SLOT_W-1:0]  stk_raddr;

    logic               push;
    logic               can_push;
    logic               p_kind;
    logic [SLOT_W-1:0]  p_slot;
    logic               p_full;
    logic [DST_W-1:0]   p_dest;
    logic [SRC_W-1:0]   p_src;
    logic [LEN_W-1:0]   p_len;
    logic               p_last;
    logic [DST_W-1:0]   run_dest;
    logic [SRC_W-1:0]   run_src;
    logic [LEN_W-1:0]   run_len;
    logic [SLOT_W-1:0]  s;
    logic [SLOT_W-1:0]  idx;
    logic               cur;
    logic               at_end;
    logic               extend;
    logic               free_ok;
    logic [CFG_W-1:0]   cap_in;

    assign can_push = !r_out_valid || !i_out_stall;
    assign s        = i_cmd.slot;
    assign idx      = r_idx[SLOT_W-1:0];
    assign cur      = r_dirty[idx];
    assign at_end   = (r_idx == r_live);
    assign extend   = r_adj && (r_len < r_cap);
    assign free_ok  = ({1'b0, s} < r_live) && !r_onstk[s];
    assign stk_waddr = r_depth[SLOT_W-1:0];
    assign stk_raddr = SLOT_W'(r_depth - CNT_W'(1));

    assign run_dest = DST_W'(32'(r_rs) * SLOT_WORDS);
    assign run_src  = SRC_W'(32'(r_total) * HEADER_WORDS + 32'(r_data) * SLOT_WORDS);
    assign run_len  = LEN_W'(32'(r_len) * SLOT_WORDS);

    always_comb begin
        if (i_cfg_data == '0) begin
            cap_in = CFG_W'(1);
        end else if (i_cfg_data > CFG_W'(RUN_CAP)) begin
            cap_in = CFG_W'(RUN_CAP);
        end else begin
            cap_in = i_cfg_data;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_cap    = i_cfg_valid ? cap_in : r_cap;
        n_live   = r_live;
        n_depth  = r_depth;
        n_dirty  = r_dirty;
        n_onstk  = r_onstk;
        n_idx    = r_idx;
        n_adj    = r_adj;
        n_len    = r_len;
        n_rs     = r_rs;
        n_k      = r_k;
        n_total  = r_total;
        n_data   = r_data;
        n_pass   = r_pass;
        o_cmd_pop = 1'b0;
        stk_we   = 1'b0;
        stk_re   = 1'b0;
        push     = 1'b0;
        p_kind   = KIND_ALLOC;
        p_slot   = '0;
        p_full   = 1'b0;
        p_dest   = '0;
        p_src    = '0;
        p_len    = '0;
        p_last   = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    case (i_cmd.op)
                        OP_ALLOC: begin
                            if (r_depth != '0) begin
                                o_cmd_pop = 1'b1;
                                stk_re    = 1'b1;
                                n_depth   = r_depth - CNT_W'(1);
                                n_state   = ST_POP;
                            end else if (can_push) begin
                                o_cmd_pop = 1'b1;
                                push      = 1'b1;
                                if (r_live < CNT_W'(SLOTS)) begin
                                    p_slot                      = r_live[SLOT_W-1:0];
                                    n_dirty[r_live[SLOT_W-1:0]] = 1'b1;
                                    n_live                      = r_live + CNT_W'(1);
                                end else begin
                                    p_full = 1'b1;
                                end
                            end
                        end
                        OP_FREE: begin
                            o_cmd_pop = 1'b1;
                            if (free_ok) begin
                                n_dirty[s] = 1'b1;
                                if ({1'b0, s} + CNT_W'(1) == r_live) begin
                                    n_live = r_live - CNT_W'(1);
                                end else if (r_depth < CNT_W'(SLOTS)) begin
                                    stk_we     = 1'b1;
                                    n_depth    = r_depth + CNT_W'(1);
                                    n_onstk[s] = 1'b1;
                                end
                            end
                        end
                        OP_MARK: begin
                            o_cmd_pop = 1'b1;
                            if ({1'b0, s} < r_live) begin
                                n_dirty[s] = 1'b1;
                            end
                        end
                        default: begin
                            o_cmd_pop = 1'b1;
                            n_state   = ST_SCAN;
                            n_pass    = 1'b0;
                            n_idx     = '0;
                            n_adj     = 1'b0;
                            n_len     = '0;
                            n_k       = '0;
                            n_data    = '0;
                        end
                    endcase
                end
            end
            ST_POP: begin
                if (can_push) begin
                    push                = 1'b1;
                    p_slot              = r_pop_slot;
                    n_dirty[r_pop_slot] = 1'b1;
                    n_onstk[r_pop_slot] = 1'b0;
                    n_state             = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (at_end) begin
                    if (!r_pass) begin
                        if (r_k == '0) begin
                            n_dirty = '0;
                            n_state = ST_IDLE;
                        end else begin
                            n_total = r_k;
                            n_pass  = 1'b1;
                            n_idx   = '0;
                            n_adj   = 1'b0;
                            n_len   = '0;
                            n_k     = '0;
                            n_data  = '0;
                        end
                    end else if (can_push) begin
                        push   = 1'b1;
                        p_kind = KIND_PATCH;
                        p_dest = run_dest;
                        p_src  = run_src;
                        p_len  = run_len;
                        p_last = 1'b1;
                        for (int j = 0; j < SLOTS; j++) begin
                            if (CNT_W'(j) >= r_live) begin
                                n_dirty[j] = 1'b0;
                            end
                        end
                        n_state = ST_IDLE;
                    end
                end else if (cur && extend) begin
                    n_len = r_len + CNT_W'(1);
                    n_idx = r_idx + CNT_W'(1);
                    if (r_pass) begin
                        n_dirty[idx] = 1'b0;
                    end
                end else if (cur) begin
                    if (r_k == RUN_W'(MAX_RUNS)) begin
                        if (!r_pass) begin
                            n_total = r_k;
                            n_pass  = 1'b1;
                            n_idx   = '0;
                            n_adj   = 1'b0;
                            n_len   = '0;
                            n_k     = '0;
                            n_data  = '0;
                        end else if (can_push) begin
                            push    = 1'b1;
                            p_kind  = KIND_PATCH;
                            p_dest  = run_dest;
                            p_src   = run_src;
                            p_len   = run_len;
                            p_last  = 1'b1;
                            n_state = ST_IDLE;
                        end
                    end else if (!r_pass || r_k == '0 || can_push) begin
                        if (r_pass && r_k != '0) begin
                            push   = 1'b1;
                            p_kind = KIND_PATCH;
                            p_dest = run_dest;
                            p_src  = run_src;
                            p_len  = run_len;
                            n_data = r_data + r_len;
                        end
                        n_rs  = idx;
                        n_len = CNT_W'(1);
                        n_k   = r_k + RUN_W'(1);
                        n_adj = 1'b1;
                        n_idx = r_idx + CNT_W'(1);
                        if (r_pass) begin
                            n_dirty[idx] = 1'b0;
                        end
                    end
                end else begin
                    n_adj = 1'b0;
                    n_idx = r_idx + CNT_W'(1);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        n_out_valid = push ? 1'b1 : (r_out_valid && i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            r_stack[stk_waddr] <= s;
        end
        if (stk_re) begin
            r_pop_slot <= r_stack[stk_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cap       <= CFG_W'(CAP_RESET);
            r_live      <= '0;
            r_depth     <= '0;
            r_dirty     <= '0;
            r_onstk     <= '0;
            r_idx       <= '0;
            r_adj       <= 1'b0;
            r_len       <= '0;
            r_k         <= '0;
            r_total     <= '0;
            r_data      <= '0;
            r_pass      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cap       <= n_cap;
            r_live      <= n_live;
            r_depth     <= n_depth;
            r_dirty     <= n_dirty;
            r_onstk     <= n_onstk;
            r_idx       <= n_idx;
            r_adj       <= n_adj;
            r_len       <= n_len;
            r_k         <= n_k;
            r_total     <= n_total;
            r_data      <= n_data;
            r_pass      <= n_pass;
            r_out_valid <= n_out_valid;
        end
        r_rs <= n_rs;
        if (push) begin
            o_result_kind  <= p_kind;
            o_granted_slot <= p_slot;
            o_table_full   <= p_full;
            o_dest_word    <= p_dest;
            o_source_word  <= p_src;
            o_length_words <= p_len;
            o_last_patch   <= p_last;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

/* src/dspb_checker.sv */
`include "dirty_slot_patch_builder_assert.svh"

module dspb_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input logic [dspb_pkg::OP_W-1:0]     i_operation,
    input logic [dspb_pkg::SLOT_W-1:0]   i_slot_index,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic                          o_result_kind,
    input logic [dspb_pkg::SLOT_W-1:0]   o_granted_slot,
    input logic                          o_table_full,
    input logic [dspb_pkg::DST_W-1:0]    o_dest_word,
    input logic [dspb_pkg::SRC_W-1:0]    o_source_word,
    input logic [dspb_pkg::LEN_W-1:0]    o_length_words,
    input logic                          o_last_patch
);
    import dspb_pkg::*;

    `DSPB_ASSERT(a_in_hold, i_clk, i_rst_n, i_in_valid && o_in_stall |=> i_in_valid && $stable(i_operation) && $stable(i_slot_index), "stalled input beat changed")
    `DSPB_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_result_kind) && $stable(o_granted_slot) && $stable(o_dest_word) && $stable(o_source_word) && $stable(o_length_words), "stalled beat changed")
    `DSPB_IMPLY(a_reply_clean, i_clk, i_rst_n, o_out_valid && o_result_kind == KIND_ALLOC, o_dest_word == '0 && o_source_word == '0 && o_length_words == '0 && !o_last_patch, "allocation reply carries patch fields")
    `DSPB_IMPLY(a_patch_clean, i_clk, i_rst_n, o_out_valid && o_result_kind == KIND_PATCH, o_granted_slot == '0 && !o_table_full && o_length_words != '0, "bad patch descriptor")
    `DSPB_IMPLY(a_full_reply, i_clk, i_rst_n, o_out_valid && o_table_full, o_granted_slot == '0 && o_result_kind == KIND_ALLOC, "full reply grants a slot")

endmodule

bind dirty_slot_patch_builder dspb_checker u_dspb_checker (.*);
